/* rtl/utf8cc_pkg.sv */
// ----------------------------------------------------------------------------
// utf8cc_pkg
// Types, codes and helper functions shared by the UTF-8 classifier modules.
// ----------------------------------------------------------------------------
package utf8cc_pkg;

   localparam int MaxResults = 4;
   localparam int PendDepth  = 3;

   localparam logic [1:0] KIND_ASCII    = 2'd0;
   localparam logic [1:0] KIND_MULTI    = 2'd1;
   localparam logic [1:0] KIND_FALLBACK = 2'd2;

   localparam logic [2:0] NEED_INVALID = 3'd0;
   localparam logic [2:0] NEED_ASCII   = 3'd1;
   localparam logic [2:0] NEED_TWO     = 3'd2;
   localparam logic [2:0] NEED_THREE   = 3'd3;
   localparam logic [2:0] NEED_FOUR    = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  char_kind;
      logic        beyond_bmp;
      logic        is_combining;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  char_kind;
      logic        beyond_bmp;
      logic        is_combining;
   } res_type;

   typedef struct packed {
      res_type [MaxResults-1:0] res;
      logic [1:0]               last_idx;
   } bundle_type;

   typedef struct packed {
      logic       pend_we;
      logic [1:0] pend_idx;
      logic [7:0] pend_byte;
      logic [1:0] count;
      logic       seen;
   } upd_type;

   function automatic logic [2:0] lead_need(input logic [7:0] b);
      logic [2:0] n;
      begin
         if (b[7] == 1'b0) begin
            n = NEED_ASCII;
         end else if (b[7:5] == 3'b110) begin
            n = NEED_TWO;
         end else if (b[7:4] == 4'b1110) begin
            n = NEED_THREE;
         end else if (b[7:3] == 5'b11110) begin
            n = NEED_FOUR;
         end else begin
            n = NEED_INVALID;
         end
         return n;
      end
   endfunction

   function automatic logic in_comb_range(input logic [20:0] cp);
      return ((cp >= 21'h000300) && (cp <= 21'h00036F)) ||
             ((cp >= 21'h001DC0) && (cp <= 21'h001DFF)) ||
             ((cp >= 21'h0020D0) && (cp <= 21'h0020FF)) ||
             ((cp >= 21'h00FE20) && (cp <= 21'h00FE2F));
   endfunction

   function automatic res_type make_res(input logic [20:0] cp, input logic [1:0] kind,
                                        input logic seen);
      res_type r;
      begin
         r.code_point   = cp;
         r.char_kind    = kind;
         r.beyond_bmp   = |cp[20:16];
         r.is_combining = seen && in_comb_range(cp);
         return r;
      end
   endfunction

endpackage

/* rtl/utf8cc_decode.sv */
// ----------------------------------------------------------------------------
// utf8cc_decode
// Decodes one byte against the pending sequence: builds the result bundle
// and the next pending-byte and first-character state.
// ----------------------------------------------------------------------------
module utf8cc_decode
   import utf8cc_pkg::*;
(
   input  req_type               item,
   input  logic [PendDepth-1:0][7:0] pend,
   input  logic [1:0]            count,
   input  logic                  char_seen,
   output bundle_type            bundle,
   output logic [2:0]            nres,
   output upd_type               upd
);

   logic                  is_end;
   logic                  is_cont;
   logic [2:0]            byte_need;
   logic [2:0]            held_need;
   logic [2:0]            fb_count;
   logic                  tail_valid;
   logic [20:0]           tail_cp;
   logic [1:0]            tail_kind;
   logic [20:0]           multi_cp;
   logic [MaxResults-1:0][7:0] seq;

   always_comb begin
      is_end    = item.end_of_string || (item.text_byte == 8'h00);
      is_cont   = (item.text_byte[7:6] == 2'b10);
      byte_need = lead_need(item.text_byte);
      held_need = lead_need(pend[0]);

      case (held_need)
         NEED_TWO: begin
            multi_cp = {10'd0, pend[0][4:0], item.text_byte[5:0]};
         end
         NEED_THREE: begin
            multi_cp = {5'd0, pend[0][3:0], pend[1][5:0], item.text_byte[5:0]};
         end
         default: begin
            multi_cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], item.text_byte[5:0]};
         end
      endcase

      fb_count       = 3'd0;
      tail_valid     = 1'b0;
      tail_cp        = {13'd0, item.text_byte};
      tail_kind      = KIND_ASCII;
      upd.pend_we    = 1'b0;
      upd.pend_idx   = 2'd0;
      upd.pend_byte  = item.text_byte;
      upd.count      = count;

      if (is_end) begin
         fb_count  = {1'b0, count};
         upd.count = 2'd0;
      end else if ((count != 2'd0) && is_cont) begin
         if (({1'b0, count} + 3'd1) == held_need) begin
            tail_valid = 1'b1;
            tail_cp    = multi_cp;
            tail_kind  = KIND_MULTI;
            upd.count  = 2'd0;
         end else begin
            upd.pend_we  = 1'b1;
            upd.pend_idx = count;
            upd.count    = count + 2'd1;
         end
      end else begin
         fb_count  = {1'b0, count};
         upd.count = 2'd0;
         if (byte_need == NEED_ASCII) begin
            tail_valid = 1'b1;
            tail_kind  = KIND_ASCII;
         end else if (byte_need == NEED_INVALID) begin
            tail_valid = 1'b1;
            tail_kind  = KIND_FALLBACK;
         end else begin
            upd.pend_we  = 1'b1;
            upd.pend_idx = 2'd0;
            upd.count    = 2'd1;
         end
      end

      seq = {8'h00, pend};
      for (int k = 0; k < MaxResults; k++) begin
         if (3'(k) < fb_count) begin
            bundle.res[k] = make_res({13'd0, seq[k]}, KIND_FALLBACK, char_seen || (k != 0));
         end else begin
            bundle.res[k] = make_res(tail_cp, tail_kind, char_seen || (k != 0));
         end
      end

      nres            = fb_count + {2'b00, tail_valid};
      bundle.last_idx = 2'(nres - 3'd1);
      upd.seen        = is_end ? 1'b0 : (char_seen || (nres != 3'd0));
   end

endmodule

/* rtl/utf8cc_emit.sv */
// ----------------------------------------------------------------------------
// utf8cc_emit
// Result register: holds one item's result bundle and hands its entries out
// one transfer at a time.
// ----------------------------------------------------------------------------
module utf8cc_emit
   import utf8cc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle_in,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_item
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   bundle_type bundle_ff, bundle_in_q;
   logic       is_last;
   logic       done;
   res_type    cur;

   always_comb begin
      is_last     = (idx_ff == bundle_ff.last_idx);
      done        = valid_ff && !rsp_stall && is_last;
      free        = !valid_ff || done;
      valid_in    = load ? 1'b1 : (done ? 1'b0 : valid_ff);
      bundle_in_q = load ? bundle_in : bundle_ff;
      if (load) begin
         idx_in = 2'd0;
      end else if (valid_ff && !rsp_stall) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
      cur                   = bundle_ff.res[idx_ff];
      rsp_valid             = valid_ff;
      rsp_item.code_point   = cur.code_point;
      rsp_item.char_kind    = cur.char_kind;
      rsp_item.beyond_bmp   = cur.beyond_bmp;
      rsp_item.is_combining = cur.is_combining;
      rsp_item.run_last     = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      bundle_ff <= bundle_in_q;
   end

endmodule

/* rtl/utf8_codepoint_classifier.sv */
// ----------------------------------------------------------------------------
// utf8_codepoint_classifier
// Streaming UTF-8 decoder with single-byte fallback for broken sequences.
//
// req_ channel: one text byte (or end of string) per transfer. A zero byte
// also ends the string. rsp_ channel: one code point per transfer, with its
// kind, beyond-BMP and combining flags; run_last marks the last result of
// an input byte. A byte may yield no result (sequence still open) or up to
// four (pending bytes flushed as fallbacks plus the new byte).
// Each byte passes the input register, then the result register, before its
// first result is valid. One byte per cycle while each byte yields at most
// one result and rsp_stall is low; a byte with several results holds the
// result register until its last result transfers, and the next byte waits
// in the input register meanwhile.
// Reset clears the pending-sequence count, the first-character flag and any
// results not yet taken. While rsp_stall is high the current result holds,
// and one further byte waits in the input register before req_stall rises.
// ----------------------------------------------------------------------------
module utf8_codepoint_classifier
   import utf8cc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic                      in_valid_ff, in_valid_in;
   req_type                   in_item_ff, in_item_in;
   logic [PendDepth-1:0][7:0] pend_ff;
   logic [1:0]                count_ff;
   logic                      seen_ff;
   logic                      req_accept;
   logic                      fire;
   logic                      emit_free;
   bundle_type                bundle;
   logic [2:0]                nres;
   upd_type                   upd;

   utf8cc_decode u_decode (
      .item      (in_item_ff),
      .pend      (pend_ff),
      .count     (count_ff),
      .char_seen (seen_ff),
      .bundle    (bundle),
      .nres      (nres),
      .upd       (upd)
   );

   utf8cc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && (nres != 3'd0)),
      .bundle_in (bundle),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always_comb begin
      fire        = in_valid_ff && emit_free;
      req_stall   = in_valid_ff && !emit_free;
      req_accept  = req_valid && !req_stall;
      in_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_item_in  = req_accept ? req_item : in_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= 2'd0;
         seen_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            count_ff <= upd.count;
            seen_ff  <= upd.seen;
         end
      end
      in_item_ff <= in_item_in;
      if (fire && upd.pend_we) begin
         pend_ff[upd.pend_idx] <= upd.pend_byte;
      end
   end

   a_fallback_plain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.char_kind == KIND_FALLBACK)) |->
         (!rsp_item.beyond_bmp && !rsp_item.is_combining))
      else $error("fallback result carries a classification flag");

   a_ascii_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.char_kind == KIND_ASCII)) |->
         (rsp_item.code_point[20:7] == 14'd0))
      else $error("ascii result above 0x7F");

   a_full_pending_lead: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd3) |-> (pend_ff[0][7:3] == 5'b11110))
      else $error("three pending bytes without a four-byte lead");

endmodule
